// ----- hw/rtl/hnt_pkg.sv -----
`timescale 1ns / 1ps

package hnt_pkg;

    // Widths fixed by the command and result words.
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 4;

    // Default number of note slots in the ring.
    localparam int SLOT_COUNT_DEF = 8;

    // Operation codes carried in the command word.
    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_NEXT     = 2'd2
    } t_op;

    // Command word.
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  velocity;
    } t_cmd;

    // Result word.
    typedef struct packed {
        logic [NOTE_W-1:0]  selected_note;
        logic [COUNT_W-1:0] held_count;
        logic               add_dropped;
    } t_result;

endpackage

// ----- hw/rtl/hnt_cell.sv -----
`timescale 1ns / 1ps

module hnt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [hnt_pkg::NOTE_W-1:0] i_slot,
    output logic [hnt_pkg::NOTE_W-1:0] o_slot,
    output logic                      o_held
);
    import hnt_pkg::*;

    logic [NOTE_W-1:0] r_slot;

    // One slot of the ring; it takes its neighbour's note on every shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_held = (r_slot != '0);

endmodule

// ----- hw/rtl/held_note_table_round_robin.sv -----
`timescale 1ns / 1ps

// Held-note table with round-robin readout. A command word is taken when start
// is high and busy is low; busy then stays high while the ring of slot cells
// rotates once, one slot a cycle, past the processing point at its head. The
// result word appears on o_result, marked by o_valid, for exactly one cycle
// straight after busy falls, and it cannot be held off: the receiver must take
// it in that cycle. A new command may be started in the cycle that carries the
// result. After reset the table is empty and needs no clearing pass.

module held_note_table_round_robin #(
    parameter int SLOT_COUNT = hnt_pkg::SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  hnt_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_valid,
    output hnt_pkg::t_result o_result
);
    import hnt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // Control and captured command.
    logic               r_busy;
    logic               r_valid;
    logic [IDX_W-1:0]   r_step;
    t_cmd               r_cmd;
    t_result            r_result;
    logic [IDX_W-1:0]   r_scan_start;

    // Accumulators gathered as the slots pass the head.
    logic               r_placed;
    logic [COUNT_W-1:0] r_count;
    logic               r_hi_found;
    logic [NOTE_W-1:0]  r_hi_note;
    logic [IDX_W-1:0]   r_hi_idx;
    logic               r_lo_found;
    logic [NOTE_W-1:0]  r_lo_note;
    logic [IDX_W-1:0]   r_lo_idx;

    logic               n_placed;
    logic [COUNT_W-1:0] n_count;
    logic               n_hi_found;
    logic [NOTE_W-1:0]  n_hi_note;
    logic [IDX_W-1:0]   n_hi_idx;
    logic               n_lo_found;
    logic [NOTE_W-1:0]  n_lo_note;
    logic [IDX_W-1:0]   n_lo_idx;
    t_result            n_result;
    logic [IDX_W-1:0]   n_scan_start;

    logic [NOTE_W-1:0]  w_slot [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] w_held;
    logic [NOTE_W-1:0]  w_head_new;
    logic               w_accept;
    logic               w_last;
    logic               w_op_on;
    logic               w_op_rel;
    logic               w_op_next;
    logic [NOTE_W-1:0]  w_head;

    assign w_accept = start && !r_busy;
    assign w_last   = r_busy && (r_step == LAST_IDX);
    assign w_head   = w_slot[0];

    // Ring of slot cells; the head's processed note re-enters at the tail.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        logic [NOTE_W-1:0] w_in;
        if (g == SLOT_COUNT - 1) begin : g_tail
            assign w_in = w_head_new;
        end else begin : g_mid
            assign w_in = w_slot[g+1];
        end
        hnt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_busy),
            .i_slot  (w_in),
            .o_slot  (w_slot[g]),
            .o_held  (w_held[g])
        );
    end

    // Decode the captured operation; a velocity of zero turns note on into release.
    always_comb begin
        w_op_on   = 1'b0;
        w_op_rel  = 1'b0;
        w_op_next = 1'b0;
        case (r_cmd.operation)
            OP_NOTE_ON: begin
                w_op_on  = (r_cmd.velocity != '0);
                w_op_rel = (r_cmd.velocity == '0);
            end
            OP_NOTE_OFF: begin
                w_op_rel = 1'b1;
            end
            OP_NEXT: begin
                w_op_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Work on the slot at the head; r_step is its place in the table.
    always_comb begin
        w_head_new = w_head;
        n_placed   = r_placed;
        n_hi_found = r_hi_found;
        n_hi_note  = r_hi_note;
        n_hi_idx   = r_hi_idx;
        n_lo_found = r_lo_found;
        n_lo_note  = r_lo_note;
        n_lo_idx   = r_lo_idx;

        // The first empty slot takes the note on, even a note of zero.
        if (w_op_on && !r_placed && !w_held[0]) begin
            w_head_new = r_cmd.note_number;
            n_placed   = 1'b1;
        end
        if (w_op_rel && (w_head == r_cmd.note_number)) begin
            w_head_new = '0;
        end

        // Round-robin search: a hit at or after the start point wins over one before it.
        if (w_op_next && w_held[0]) begin
            if (r_step >= r_scan_start) begin
                if (!r_hi_found) begin
                    n_hi_found = 1'b1;
                    n_hi_note  = w_head;
                    n_hi_idx   = r_step;
                end
            end else if (!r_lo_found) begin
                n_lo_found = 1'b1;
                n_lo_note  = w_head;
                n_lo_idx   = r_step;
            end
        end

        n_count = r_count + COUNT_W'(w_head_new != '0);

        // Result and new scan start, used at the last step.
        n_result.held_count    = n_count;
        n_result.add_dropped   = w_op_on && !n_placed;
        n_result.selected_note = '0;
        n_scan_start           = r_scan_start;
        if (n_hi_found) begin
            n_result.selected_note = n_hi_note;
            n_scan_start = (n_hi_idx == LAST_IDX) ? '0 : n_hi_idx + 1'b1;
        end else if (n_lo_found) begin
            n_result.selected_note = n_lo_note;
            n_scan_start = (n_lo_idx == LAST_IDX) ? '0 : n_lo_idx + 1'b1;
        end
    end

    // Sequencing of one command through the ring.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_valid      <= 1'b0;
            r_step       <= '0;
            r_scan_start <= '0;
        end else begin
            r_valid <= w_last;
            if (w_accept) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_last) begin
                    r_busy       <= 1'b0;
                    r_scan_start <= n_scan_start;
                end
            end
        end
    end

    // Captured command, accumulators and the result word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_cmd;
            r_placed   <= 1'b0;
            r_count    <= '0;
            r_hi_found <= 1'b0;
            r_lo_found <= 1'b0;
        end else if (r_busy) begin
            r_placed   <= n_placed;
            r_count    <= n_count;
            r_hi_found <= n_hi_found;
            r_hi_note  <= n_hi_note;
            r_hi_idx   <= n_hi_idx;
            r_lo_found <= n_lo_found;
            r_lo_note  <= n_lo_note;
            r_lo_idx   <= n_lo_idx;
        end
        if (w_last) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The last step of a pass always yields a result word next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last |=> o_valid)
        else $error("no result after the final step");

    // A result word is only shown once the ring has stopped.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !r_busy)
        else $error("result shown while still busy");

    // Only a note on can report a dropped note.
    a_drop_only_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.add_dropped) |-> (r_cmd.operation == OP_NOTE_ON))
        else $error("drop flagged for an operation other than note on");

    // Only a next request can select a note.
    a_select_only_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.selected_note != '0)) |-> (r_cmd.operation == OP_NEXT))
        else $error("note selected for an operation other than next");

endmodule

// ----- tb/sv/held_note_table_round_robin_tb.sv -----
`timescale 1ns / 1ps

module held_note_table_round_robin_tb;

    import hnt_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 550;

    // Mirror of the held-note table that predicts every result word and
    // checks each one as it leaves the block.
    class note_table_board;
        logic [NOTE_W-1:0] slot_note [SLOTS];
        int unsigned       scan_from;
        t_result           pending [$];
        int unsigned       faults;
        int unsigned       results_seen;
        int unsigned       drops_seen;
        int unsigned       op_seen [4];

        function new();
            foreach (slot_note[i]) slot_note[i] = '0;
            scan_from = 0;
            faults = 0;
            results_seen = 0;
            drops_seen = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        // Empties every slot that holds the note; note zero only matches
        // slots that are already empty.
        function void release_slots(logic [NOTE_W-1:0] note);
            foreach (slot_note[i]) begin
                if (slot_note[i] == note) slot_note[i] = '0;
            end
        endfunction

        // Applies one accepted command word and queues its result word.
        function void note_command(t_cmd c);
            t_result     r;
            bit          done;
            int unsigned held;
            int unsigned first;
            int unsigned idx;
            r = '0;
            done = 1'b0;
            held = 0;
            first = scan_from;
            op_seen[c.operation]++;
            case (c.operation)
                OP_NOTE_ON: begin
                    if (c.velocity != '0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!done && slot_note[i] == '0) begin
                                slot_note[i] = c.note_number;
                                done = 1'b1;
                            end
                        end
                        r.add_dropped = !done;
                    end else begin
                        release_slots(c.note_number);
                    end
                end
                OP_NOTE_OFF: begin
                    release_slots(c.note_number);
                end
                OP_NEXT: begin
                    // Round-robin search from the slot after the last one served.
                    for (int k = 0; k < SLOTS; k++) begin
                        idx = (first + k) % SLOTS;
                        if (!done && slot_note[idx] != '0) begin
                            r.selected_note = slot_note[idx];
                            scan_from = (idx + 1) % SLOTS;
                            done = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            foreach (slot_note[i]) begin
                if (slot_note[i] != '0) held++;
            end
            r.held_count = held[COUNT_W-1:0];
            pending.push_back(r);
        endfunction

        // Compares a result word with the oldest prediction.
        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (got.add_dropped) drops_seen++;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t: result word with none expected: note %0d count %0d drop %0b",
                             $realtime, got.selected_note, got.held_count, got.add_dropped);
                end
            end else begin
                want = pending.pop_front();
                if (got.selected_note !== want.selected_note
                        || got.held_count !== want.held_count
                        || got.add_dropped !== want.add_dropped) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("%0t: mismatch: note %0d/%0d count %0d/%0d drop %0b/%0b %s",
                                 $realtime, got.selected_note, want.selected_note,
                                 got.held_count, want.held_count,
                                 got.add_dropped, want.add_dropped, "(actual/expected)");
                    end
                end
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    note_table_board   board;
    int unsigned       sender_idle_pct;
    logic [NOTE_W-1:0] note_pool [12];

    held_note_table_round_robin #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Presents one command word, after idling the sender for a random number
    // of single cycles, and waits until the block takes it.
    task automatic send_command(input t_cmd c);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note_command(c);
    endtask

    task automatic send_fields(input logic [OP_W-1:0] op, input int note, input int vel);
        t_cmd c;
        c.operation = op;
        c.note_number = note[NOTE_W-1:0];
        c.velocity = vel[VEL_W-1:0];
        send_command(c);
    endtask

    // Random command word: notes mostly from a small pool so that releases
    // hit held notes and the table fills and drains.
    function automatic t_cmd random_command();
        t_cmd        c;
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(99);
        if (pick < 42) c.operation = OP_NOTE_ON;
        else if (pick < 66) c.operation = OP_NOTE_OFF;
        else if (pick < 95) c.operation = OP_NEXT;
        else c.operation = OP_UNUSED;
        if ($urandom_range(3) == 0) c.note_number = NOTE_W'($urandom_range(127));
        else c.note_number = note_pool[$urandom_range(11)];
        v = $urandom_range(9);
        if (v == 0) c.velocity = '0;
        else if (v == 1) c.velocity = 7'd127;
        else c.velocity = VEL_W'($urandom_range(1, 127));
        return c;
    endfunction

    // Result words are taken at the rising edge that ends their cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_result);
    end

    initial begin
        board = new();
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        sender_idle_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: field extremes, every operation and the corner cases.
        send_fields(OP_NEXT, 0, 0);
        send_fields(OP_NOTE_ON, 127, 127);
        send_fields(OP_NOTE_ON, 1, 1);
        send_fields(OP_NOTE_ON, 0, 64);
        send_fields(OP_NOTE_ON, 64, 100);
        send_fields(OP_NOTE_ON, 64, 2);
        send_fields(OP_NOTE_OFF, 0, 127);
        send_fields(OP_NEXT, 0, 0);
        send_fields(OP_NOTE_ON, 100, 127);
        send_fields(OP_NOTE_ON, 2, 3);
        send_fields(OP_NOTE_ON, 3, 85);
        send_fields(OP_NOTE_ON, 126, 42);
        send_fields(OP_NOTE_ON, 5, 127);
        send_fields(OP_NOTE_ON, 0, 1);
        send_fields(OP_NEXT, 127, 127);
        send_fields(OP_NEXT, 0, 0);
        send_fields(OP_UNUSED, 127, 127);
        send_fields(OP_NOTE_ON, 64, 0);
        send_fields(OP_NOTE_OFF, 127, 0);
        send_fields(OP_NEXT, 0, 0);
        send_fields(OP_NOTE_OFF, 1, 9);
        send_fields(OP_NOTE_OFF, 100, 0);
        send_fields(OP_NOTE_OFF, 2, 0);
        send_fields(OP_NOTE_OFF, 3, 0);
        send_fields(OP_NOTE_OFF, 126, 0);
        send_fields(OP_NEXT, 0, 0);

        // Random words in three phases of sender idling.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 53 : 0;
            foreach (note_pool[i]) note_pool[i] = NOTE_W'($urandom_range(1, 127));
            for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
                send_command(random_command());
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);

        $display("Sent %0d note-on, %0d note-off, %0d next and %0d unused command words.",
                 board.op_seen[0], board.op_seen[1], board.op_seen[2], board.op_seen[3]);
        $display("Checked %0d result words, %0d of them dropped note-ons; %0d faults.",
                 board.results_seen, board.drops_seen, board.faults);
        if (board.faults == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2ms;
        $display("Timed out with %0d result words outstanding.", board.pending.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/hnt_pkg.sv
hw/rtl/hnt_cell.sv
hw/rtl/held_note_table_round_robin.sv
tb/sv/held_note_table_round_robin_tb.sv
